@@ design/ola_pkg.sv @@
// Shared operation and result codes and the command and status structs for the ordered list.
`timescale 1ns / 1ps
`default_nettype none

package ola_pkg;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ENTRY    = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic       in_load;
        logic       rd_en;
        logic       wr_en;
        logic       wr_sel_rdata;
        logic       count_inc;
        logic       count_dec;
        logic       out_load;
        logic       out_entry;
        logic       out_last;
        logic [2:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ design/ola_dp.sv @@
// Datapath: entry memory, entry count, compare and the result register.
`timescale 1ns / 1ps
`default_nettype none

module ola_dp #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ola_pkg::cmd_t       cmd,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic signed [31:0]  in_value,
    output ola_pkg::stat_t           stat,
    output logic [CW-1:0]            count,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [2:0]               out_status,
    output logic signed [31:0]       out_entry_value,
    output logic                     out_last
);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic signed [31:0] out_entry_reg;
    logic               out_last_reg;
    logic signed [31:0] wr_data;

    assign wr_data = cmd.wr_sel_rdata ? rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.in_load)
        begin
            value_reg <= in_value;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_entry_reg  <= cmd.out_entry ? rdata_reg : 32'sd0;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.match    = (rdata_reg == value_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign count           = count_reg;
    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_entry_value = out_entry_reg;
    assign out_last        = out_last_reg;

endmodule

`default_nettype wire

@@ design/ola_ctrl.sv @@
// Controller: sequences append, scan-and-shift remove and the report stream.
`timescale 1ns / 1ps
`default_nettype none

module ola_ctrl #(
    parameter int CAPACITY = 32,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire logic [1:0]     func,
    input  wire ola_pkg::stat_t stat,
    input  wire logic [CW-1:0]  count,
    output ola_pkg::cmd_t       cmd,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       wr_addr
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPEND = 3'd1;
    localparam logic [2:0] S_RESP   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] ra_reg, ra_next;
    logic [CW-1:0] da_reg, da_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [2:0]    rsp_reg, rsp_next;

    logic          more;
    logic          take;
    logic          issue;
    logic          last_hit;
    logic [CW-1:0] da_m1;
    logic [CW-1:0] da_p1;

    assign more     = (ra_reg < count);
    assign da_m1    = da_reg - CW'(1);
    assign da_p1    = da_reg + CW'(1);
    assign last_hit = (da_p1 == count);
    assign take     = pend_reg && stat.out_free;
    assign issue    = more && (!pend_reg || take);

    assign req_stall = (state_reg != S_IDLE);
    assign rd_addr   = ra_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        ra_next    = ra_reg;
        da_next    = da_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        rsp_next   = rsp_reg;
        cmd        = '0;
        wr_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.in_load = 1'b1;
                    ra_next     = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    case (func)
                        ola_pkg::FUNC_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        ola_pkg::FUNC_REMOVE:
                        begin
                            if (count == '0)
                            begin
                                rsp_next   = ola_pkg::ST_NOTFOUND;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ola_pkg::FUNC_REPORT:
                        begin
                            if (count == '0)
                            begin
                                rsp_next   = ola_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_REPORT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_APPEND:
            begin
                if (count >= CW'(CAPACITY))
                begin
                    rsp_next = ola_pkg::ST_FULL;
                end
                else
                begin
                    cmd.wr_en     = 1'b1;
                    wr_addr       = count[AW-1:0];
                    cmd.count_inc = 1'b1;
                    rsp_next      = ola_pkg::ST_APPENDED;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = rsp_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // read data is registered and arrives the cycle after its address; after the match
                // each entry is written one slot lower to close the gap
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        cmd.wr_en        = 1'b1;
                        cmd.wr_sel_rdata = 1'b1;
                        wr_addr          = da_m1[AW-1:0];
                    end
                    else if (stat.match)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (more)
                begin
                    cmd.rd_en = 1'b1;
                    ra_next   = ra_reg + CW'(1);
                    da_next   = ra_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (found_reg || stat.match)
                    begin
                        cmd.count_dec = 1'b1;
                        rsp_next      = ola_pkg::ST_REMOVED;
                    end
                    else
                    begin
                        rsp_next = ola_pkg::ST_NOTFOUND;
                    end
                    state_next = S_RESP;
                end
            end

            S_REPORT:
            begin
                if (take)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ola_pkg::ST_ENTRY;
                    cmd.out_entry  = 1'b1;
                    cmd.out_last   = last_hit;
                    if (last_hit)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (issue)
                begin
                    cmd.rd_en = 1'b1;
                    ra_next   = ra_reg + CW'(1);
                    da_next   = ra_reg;
                    pend_next = 1'b1;
                end
                else if (take)
                begin
                    pend_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ra_reg    <= '0;
            da_reg    <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            rsp_reg   <= ola_pkg::ST_APPENDED;
        end
        else
        begin
            state_reg <= state_next;
            ra_reg    <= ra_next;
            da_reg    <= da_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            rsp_reg   <= rsp_next;
        end
    end

endmodule

`default_nettype wire

@@ design/ordered_list_append_remove_dump.sv @@
// Top level of the ordered list: controller plus datapath.
//
//   channel   signals                           dir   accepted when
//   request   req_valid req_stall func value    in    req_valid && !req_stall
//   result    rsp_valid rsp_stall status        out   rsp_valid && !rsp_stall
//             entry_value last
//
// Append writes at the entry count unless full; remove makes one memory read
// per entry through the single read port, shifting in the same pass (none on an
// empty list); report streams one entry per cycle while results are not stalled.
// A finished result waits in the output register; a stalled result holds the
// sequencer only where the next result needs that register.
// Reset clears the entry count and all control state; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_append_remove_dump #(
    parameter int CAPACITY = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [31:0] value,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic [2:0]              status,
    output logic signed [31:0]      entry_value,
    output logic                    last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    ola_pkg::cmd_t  cmd;
    ola_pkg::stat_t stat;
    logic [CW-1:0]  count;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    ola_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .stat      (stat),
        .count     (count),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    ola_dp #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .in_value        (value),
        .stat            (stat),
        .count           (count),
        .out_stall       (rsp_stall),
        .out_valid       (rsp_valid),
        .out_status      (status),
        .out_entry_value (entry_value),
        .out_last        (last)
    );

endmodule

`default_nettype wire

@@ design/ola_chk.sv @@
// Port-level checker for the ordered list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ola_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic [1:0]         func,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire logic [2:0]         status,
    input wire logic signed [31:0] entry_value,
    input wire logic               last
);

    // a held result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(entry_value) && $stable(last))
        else $error("held result changed");

    // any real operation, once taken, makes the block busy so that it stalls further requests
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && func != ola_pkg::FUNC_NOP |=> req_stall)
        else $error("request taken without going busy");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ola_pkg::ST_ENTRY |-> last)
        else $error("single-result request without last");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ola_pkg::ST_ENTRY |-> entry_value == 32'sd0)
        else $error("nonzero value on a non-entry result");

endmodule

bind ordered_list_append_remove_dump ola_chk u_ola_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .entry_value (entry_value),
    .last        (last)
);

`default_nettype wire
